// ===== sv/xcrc_pkg.sv =====
// Shared types, constants and the CRC-16/XMODEM byte step of the XMODEM-CRC receiver.
package xcrc_pkg;

    localparam int ADDR_BITS   = 20;
    localparam int SMALL_BLOCK = 128;
    localparam int LARGE_BLOCK = 1024;

    localparam int SIZE_BITS = 21;
    localparam int IDX_BITS  = 11;
    localparam int RETRY_BITS = 8;
    localparam int CFG_BITS  = 21;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_CANCEL   = 3'd1;
    localparam logic [2:0] ST_BLKNUM   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;
    localparam logic [2:0] ST_NONE     = 3'd6;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BUF_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_WAIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_WAIT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RETRY      = 2'd3;

    localparam logic [SIZE_BITS-1:0]  BUF_LIMIT_RST  = 21'h100000;
    localparam logic [SIZE_BITS-1:0]  START_WAIT_RST = 21'h010000;
    localparam logic [SIZE_BITS-1:0]  DATA_WAIT_RST  = 21'h100000;
    localparam logic [RETRY_BITS-1:0] RETRY_RST      = 8'd50;

    // Output tdata layout, lowest bit first.
    localparam int OFS_SEND_VALID  = 0;
    localparam int OFS_SEND_BYTE   = 1;
    localparam int OFS_WRITE_VALID = 9;
    localparam int OFS_WRITE_ADDR  = 10;
    localparam int OFS_WRITE_DATA  = OFS_WRITE_ADDR + ADDR_BITS;
    localparam int OFS_STATUS      = OFS_WRITE_DATA + 8;
    localparam int OFS_SIZE        = OFS_STATUS + 3;
    localparam int OUT_RAW_BITS    = OFS_SIZE + SIZE_BITS;
    localparam int OUT_BITS        = ((OUT_RAW_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_START = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_BLKNUM   = 3'd1,
        PH_BLKCOMP  = 3'd2,
        PH_DATA     = 3'd3,
        PH_CRC_HI   = 3'd4,
        PH_CRC_LO   = 3'd5,
        PH_ENDED    = 3'd6
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic                 send_valid;
        logic [7:0]           send_byte;
        logic                 write_valid;
        logic [ADDR_BITS-1:0] write_addr;
        logic [7:0]           write_data;
        logic                 finished;
        logic [2:0]           status;
        logic [SIZE_BITS-1:0] received_size;
    } t_result;

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/xmodem_crc_receiver_core.sv =====
// Top level of the XMODEM-CRC / 1K-XMODEM receiver: front queue, protocol engine, stream ports.
// A result is registered: its item passes a queue slot and then the result register on the way out.
// Throughput: one item per cycle unless a result stalls, with a CRC byte and protocol step each.
// A two-entry queue between front and engine lets the input keep flowing while a result waits.
// Reset is synchronous and active low: it empties the queue and the result register,
// returns the session to waiting for a header and restores every register to its default.
module xmodem_crc_receiver_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // rx_byte
    input  logic [1:0]                          s_tuser,   // req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // send_valid, send_byte, write_valid, write_addr, write_data, status, received_size
    output logic [xcrc_pkg::OUT_BITS-1:0]       m_tdata,
    output logic                                m_tlast,   // finished
    input  logic                                i_cfg_we,
    input  logic [xcrc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [xcrc_pkg::CFG_BITS-1:0]       i_cfg_data
);
    import xcrc_pkg::*;

    logic    w_q_valid;
    logic    w_q_pop;
    t_item   w_q_item;
    t_result w_res;

    xcrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_req_type (s_tuser),
        .i_rx_byte  (s_tdata),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_q_pop    (w_q_pop)
    );

    xcrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_res_valid (m_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_tready)
    );

    assign m_tlast = w_res.finished;
    assign m_tdata = OUT_BITS'({w_res.received_size, w_res.status, w_res.write_data,
                                w_res.write_addr, w_res.write_valid, w_res.send_byte,
                                w_res.send_valid});

endmodule

// ===== sv/xcrc_front.sv =====
// Front end: classifies incoming items and holds them in a two-entry queue for the engine.
module xcrc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_req_type,
    input  logic [7:0]     i_rx_byte,
    output logic           o_q_valid,
    output xcrc_pkg::t_item o_q_item,
    input  logic           i_q_pop
);
    import xcrc_pkg::*;

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_kind      w_kind;
    logic       w_push;

    always_comb begin
        unique case (i_req_type)
            2'd0:    w_kind = KIND_BYTE;
            2'd1:    w_kind = KIND_TICK;
            2'd2:    w_kind = KIND_START;
            default: w_kind = KIND_NONE;
        endcase
    end

    // Unknown request types change nothing, so they are dropped here.
    assign o_ready   = (r_count != 2'd2);
    assign w_push    = i_valid && o_ready && (w_kind != KIND_NONE);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= '{kind: w_kind, data: i_rx_byte};
        end
    end

endmodule

// ===== sv/xcrc_back.sv =====
// Protocol engine: runs the XMODEM-CRC receive state machine and holds the result register.
module xcrc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [xcrc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [xcrc_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                           i_q_valid,
    input  xcrc_pkg::t_item                i_q_item,
    output logic                           o_q_pop,
    output logic                           o_res_valid,
    output xcrc_pkg::t_result              o_res,
    input  logic                           i_res_ready
);
    import xcrc_pkg::*;

    localparam int SUM_BITS = SIZE_BITS + 1;

    logic [SIZE_BITS-1:0]  r_buf_limit;
    logic [SIZE_BITS-1:0]  r_start_wait;
    logic [SIZE_BITS-1:0]  r_data_wait;
    logic [RETRY_BITS-1:0] r_retry_limit;

    t_phase                r_phase, n_phase;
    logic                  r_large, n_large;
    logic [IDX_BITS-1:0]   r_index, n_index;
    logic [7:0]            r_expected, n_expected;
    logic [7:0]            r_got_blk, n_got_blk;
    logic [7:0]            r_crc_hi, n_crc_hi;
    logic [15:0]           r_crc, n_crc;
    logic [SIZE_BITS-1:0]  r_total, n_total;
    logic [SIZE_BITS-1:0]  r_wait, n_wait;
    logic [RETRY_BITS-1:0] r_retry, n_retry;

    logic                  r_out_valid;
    t_result               r_out;
    t_result               w_res;
    logic                  w_has_res;
    logic [IDX_BITS-1:0]   w_len;
    logic [IDX_BITS-1:0]   w_hdr_len;
    logic [IDX_BITS-1:0]   w_idx_inc;
    logic [SIZE_BITS-1:0]  w_limit;
    logic [SIZE_BITS-1:0]  w_wait_inc;
    logic [SUM_BITS-1:0]   w_need;
    logic                  w_go;

    assign w_go        = !r_out_valid || i_res_ready;
    assign o_q_pop     = i_q_valid && w_go;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign w_len      = r_large ? IDX_BITS'(LARGE_BLOCK) : IDX_BITS'(SMALL_BLOCK);
    assign w_hdr_len  = (i_q_item.data == CH_STX) ? IDX_BITS'(LARGE_BLOCK)
                                                  : IDX_BITS'(SMALL_BLOCK);
    assign w_idx_inc  = r_index + IDX_BITS'(1);
    assign w_wait_inc = r_wait + SIZE_BITS'(1);
    assign w_need     = SUM_BITS'(r_total) + SUM_BITS'(w_hdr_len);

    always_comb begin
        w_limit = (r_phase == PH_HEADER) ? r_start_wait : r_data_wait;
        if (w_limit == '0) begin
            w_limit = SIZE_BITS'(1);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_large    = r_large;
        n_index    = r_index;
        n_expected = r_expected;
        n_got_blk  = r_got_blk;
        n_crc_hi   = r_crc_hi;
        n_crc      = r_crc;
        n_total    = r_total;
        n_wait     = r_wait;
        n_retry    = r_retry;
        w_has_res  = 1'b0;
        w_res      = '{send_valid: 1'b0, send_byte: 8'h00, write_valid: 1'b0,
                       write_addr: '0, write_data: 8'h00, finished: 1'b0,
                       status: ST_NONE, received_size: '0};

        case (i_q_item.kind)
            KIND_START: begin
                n_phase    = PH_HEADER;
                n_large    = 1'b0;
                n_index    = '0;
                n_expected = 8'd1;
                n_got_blk  = 8'h00;
                n_crc_hi   = 8'h00;
                n_crc      = 16'h0000;
                n_total    = '0;
                n_wait     = '0;
                n_retry    = '0;
            end
            KIND_TICK: begin
                if (r_phase != PH_ENDED) begin
                    if (w_wait_inc < w_limit) begin
                        n_wait = w_wait_inc;
                    end else begin
                        n_wait    = '0;
                        w_has_res = 1'b1;
                        if (r_phase == PH_HEADER) begin
                            if (r_retry == r_retry_limit) begin
                                n_phase        = PH_ENDED;
                                w_res.finished = 1'b1;
                                w_res.status   = ST_TIMEOUT;
                            end else begin
                                n_retry          = r_retry + RETRY_BITS'(1);
                                w_res.send_valid = 1'b1;
                                w_res.send_byte  = CH_C;
                            end
                        end else begin
                            n_phase          = PH_HEADER;
                            w_res.send_valid = 1'b1;
                            w_res.send_byte  = CH_NAK;
                        end
                    end
                end
            end
            KIND_BYTE: begin
                if (r_phase != PH_ENDED) begin
                    n_wait = '0;
                    unique case (r_phase)
                        PH_HEADER: begin
                            n_retry = '0;
                            if (i_q_item.data == CH_SOH || i_q_item.data == CH_STX) begin
                                n_large = (i_q_item.data == CH_STX);
                                if (w_need > SUM_BITS'(r_buf_limit)) begin
                                    n_phase        = PH_ENDED;
                                    w_has_res      = 1'b1;
                                    w_res.finished = 1'b1;
                                    w_res.status   = ST_OVERFLOW;
                                end else begin
                                    n_index = '0;
                                    n_crc   = 16'h0000;
                                    n_phase = PH_BLKNUM;
                                end
                            end else begin
                                n_phase          = PH_ENDED;
                                w_has_res        = 1'b1;
                                w_res.finished   = 1'b1;
                                w_res.send_valid = 1'b1;
                                if (i_q_item.data == CH_EOT) begin
                                    w_res.send_byte = CH_ACK;
                                    w_res.status    = ST_DONE;
                                end else if (i_q_item.data == CH_CAN) begin
                                    w_res.send_byte = CH_ACK;
                                    w_res.status    = ST_CANCEL;
                                end else begin
                                    w_res.send_byte = CH_NAK;
                                    w_res.status    = ST_INVALID;
                                end
                            end
                        end
                        PH_BLKNUM: begin
                            n_got_blk = i_q_item.data;
                            n_phase   = PH_BLKCOMP;
                        end
                        PH_BLKCOMP: begin
                            n_phase = PH_DATA;
                        end
                        PH_DATA: begin
                            n_crc             = crc_next(r_crc, i_q_item.data);
                            w_has_res         = 1'b1;
                            w_res.write_valid = 1'b1;
                            w_res.write_addr  = ADDR_BITS'(SUM_BITS'(r_total)
                                                          + SUM_BITS'(r_index));
                            w_res.write_data  = i_q_item.data;
                            n_index           = w_idx_inc;
                            if (w_idx_inc >= w_len) begin
                                n_phase = PH_CRC_HI;
                            end
                        end
                        PH_CRC_HI: begin
                            n_crc_hi = i_q_item.data;
                            n_phase  = PH_CRC_LO;
                        end
                        PH_CRC_LO: begin
                            w_has_res        = 1'b1;
                            w_res.send_valid = 1'b1;
                            if (r_got_blk != r_expected) begin
                                n_phase         = PH_ENDED;
                                w_res.finished  = 1'b1;
                                w_res.status    = ST_BLKNUM;
                                w_res.send_byte = CH_CAN;
                            end else begin
                                n_phase = PH_HEADER;
                                if ({r_crc_hi, i_q_item.data} == r_crc) begin
                                    n_total         = r_total + SIZE_BITS'(w_len);
                                    n_expected      = r_expected + 8'd1;
                                    w_res.send_byte = CH_ACK;
                                end else begin
                                    w_res.send_byte = CH_NAK;
                                end
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        w_res.received_size = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_large    <= 1'b0;
            r_index    <= '0;
            r_expected <= 8'd1;
            r_got_blk  <= 8'h00;
            r_crc_hi   <= 8'h00;
            r_crc      <= 16'h0000;
            r_total    <= '0;
            r_wait     <= '0;
            r_retry    <= '0;
        end else if (o_q_pop) begin
            r_phase    <= n_phase;
            r_large    <= n_large;
            r_index    <= n_index;
            r_expected <= n_expected;
            r_got_blk  <= n_got_blk;
            r_crc_hi   <= n_crc_hi;
            r_crc      <= n_crc;
            r_total    <= n_total;
            r_wait     <= n_wait;
            r_retry    <= n_retry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_limit   <= BUF_LIMIT_RST;
            r_start_wait  <= START_WAIT_RST;
            r_data_wait   <= DATA_WAIT_RST;
            r_retry_limit <= RETRY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUF_LIMIT:  r_buf_limit   <= i_cfg_data;
                CFG_START_WAIT: r_start_wait  <= i_cfg_data;
                CFG_DATA_WAIT:  r_data_wait   <= i_cfg_data;
                CFG_RETRY:      r_retry_limit <= i_cfg_data[RETRY_BITS-1:0];
                default:        r_retry_limit <= r_retry_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= o_q_pop && w_has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && w_has_res) begin
            r_out <= w_res;
        end
    end

endmodule

// ===== sv/xcrc_checker.sv =====
// Port-level checks of the receiver core, attached to the top level by a bind statement.
module xcrc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [xcrc_pkg::OUT_BITS-1:0]       m_tdata,
    input logic                                m_tlast
);
    import xcrc_pkg::*;

    logic       w_send_v;
    logic       w_write_v;
    logic [2:0] w_status;

    assign w_send_v  = m_tdata[OFS_SEND_VALID];
    assign w_write_v = m_tdata[OFS_WRITE_VALID];
    assign w_status  = m_tdata[OFS_STATUS +: 3];

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result changed.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("Result or back-pressure present after reset.");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(w_send_v && w_write_v))
        else $error("Response byte and buffer write in one result.");

    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (w_status != ST_NONE)) && !(m_tlast && w_write_v))
        else $error("Session end and status disagree.");

endmodule

bind xmodem_crc_receiver_core xcrc_checker u_xcrc_checker (.*);
